>>> rtl/core/billboard_quad_expand_macros.svh
// ----------------------------------------------------------------------------
// Billboard quad expander assertion macros
// Concurrent assertion wrappers shared by the RTL; empty when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef BILLBOARD_QUAD_EXPAND_MACROS_SVH
`define BILLBOARD_QUAD_EXPAND_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked assertion, quiet while reset is high
`define BQE_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
// Clocked assertion, checked through reset as well
`define BQE_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define BQE_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define BQE_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif

`endif

>>> rtl/core/bqe_pkg.sv
// ----------------------------------------------------------------------------
// Billboard quad expander package
// Shared widths, constants, record types and the 16-bit saturation helper.
// ----------------------------------------------------------------------------
package bqe_pkg;

  localparam int AXES       = 3;
  localparam int AXIS_Y     = 1;
  localparam int COORD_W    = 16;
  localparam int SIZE_W     = 16;
  localparam int DIR_W      = 16;
  localparam int TIME_W     = 16;
  localparam int DIR_FRAC   = 14;
  localparam int TIME_FRAC  = 16;
  // signed 16 x unsigned 16 product
  localparam int PROD_W     = DIR_W + SIZE_W + 1;
  localparam int SCALED_W   = PROD_W - DIR_FRAC;
  localparam int DELTA_W    = PROD_W - TIME_FRAC;
  // moved +/- scaled right +/- scaled up never leaves this width
  localparam int SUM_W      = SCALED_W + 2;

  localparam int CORNER_W   = 2;
  localparam logic [CORNER_W-1:0] CORNER_LAST = 2'd3;

  localparam int REG_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int S_TDATA_W  = 128;
  localparam int M_TDATA_W  = 96;
  localparam int MOVED_LSB  = AXES * COORD_W;

  localparam logic signed [DIR_W-1:0] WORLD_UP_ONE = 16'sd16384;
  localparam logic signed [DIR_W-1:0] RESET_ONE    = 16'sd16384;

  localparam logic signed [SUM_W-1:0] SAT_MAX = 21'sd32767;
  localparam logic signed [SUM_W-1:0] SAT_MIN = -21'sd32768;

  typedef struct packed {
    logic [AXES-1:0][DIR_W-1:0] right;
    logic [AXES-1:0][DIR_W-1:0] up;
    logic                       cylindrical;
    logic [TIME_W-1:0]          time_step;
  } bqe_cfg_t;

  // Declared high to low so that a cast from tdata puts center x lowest
  typedef struct packed {
    logic [AXES-1:0][COORD_W-1:0] vel;
    logic [SIZE_W-1:0]            size_y;
    logic [SIZE_W-1:0]            size_x;
    logic [AXES-1:0][COORD_W-1:0] center;
  } bqe_quad_t;

  typedef struct packed {
    logic [AXES-1:0][COORD_W-1:0]  moved;
    logic [AXES-1:0][SCALED_W-1:0] sr;
    logic [AXES-1:0][SCALED_W-1:0] su;
  } bqe_geom_t;

  typedef struct packed {
    logic [AXES-1:0][COORD_W-1:0] moved;
    logic [AXES-1:0][COORD_W-1:0] pos;
    logic [CORNER_W-1:0]          corner;
    logic                         last;
  } bqe_corner_t;

  function automatic logic [COORD_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[COORD_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/bqe_cfg_regs.sv
// ----------------------------------------------------------------------------
// Billboard quad expander configuration registers
// APB register file holding camera vectors, cylindrical mode and time step.
// ----------------------------------------------------------------------------
module bqe_cfg_regs import bqe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output bqe_cfg_t              cfg
);

  typedef enum logic [2:0] {
    REG_RIGHT_X,
    REG_RIGHT_Y,
    REG_RIGHT_Z,
    REG_UP_X,
    REG_UP_Y,
    REG_UP_Z,
    REG_CYLINDRICAL,
    REG_TIME_STEP
  } bqe_reg_t;

  bqe_reg_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = bqe_reg_t'(paddr[REG_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.right[0]    <= RESET_ONE;
      cfg.right[1]    <= '0;
      cfg.right[2]    <= '0;
      cfg.up[0]       <= '0;
      cfg.up[1]       <= RESET_ONE;
      cfg.up[2]       <= '0;
      cfg.cylindrical <= 1'b0;
      cfg.time_step   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RIGHT_X:     cfg.right[0]    <= pwdata[DIR_W-1:0];
        REG_RIGHT_Y:     cfg.right[1]    <= pwdata[DIR_W-1:0];
        REG_RIGHT_Z:     cfg.right[2]    <= pwdata[DIR_W-1:0];
        REG_UP_X:        cfg.up[0]       <= pwdata[DIR_W-1:0];
        REG_UP_Y:        cfg.up[1]       <= pwdata[DIR_W-1:0];
        REG_UP_Z:        cfg.up[2]       <= pwdata[DIR_W-1:0];
        REG_CYLINDRICAL: cfg.cylindrical <= pwdata[0];
        REG_TIME_STEP:   cfg.time_step   <= pwdata[TIME_W-1:0];
      endcase
    end
  end

  // Signed registers read back sign extended
  always_comb begin
    unique case (reg_idx)
      REG_RIGHT_X:     prdata = APB_DATA_W'($signed(cfg.right[0]));
      REG_RIGHT_Y:     prdata = APB_DATA_W'($signed(cfg.right[1]));
      REG_RIGHT_Z:     prdata = APB_DATA_W'($signed(cfg.right[2]));
      REG_UP_X:        prdata = APB_DATA_W'($signed(cfg.up[0]));
      REG_UP_Y:        prdata = APB_DATA_W'($signed(cfg.up[1]));
      REG_UP_Z:        prdata = APB_DATA_W'($signed(cfg.up[2]));
      REG_CYLINDRICAL: prdata = APB_DATA_W'(cfg.cylindrical);
      REG_TIME_STEP:   prdata = APB_DATA_W'(cfg.time_step);
    endcase
  end

endmodule

>>> rtl/core/bqe_quad_math.sv
// ----------------------------------------------------------------------------
// Billboard quad expander quad arithmetic
// Input register, centre motion and scaling of the right and up vectors.
// ----------------------------------------------------------------------------
module bqe_quad_math import bqe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  bqe_cfg_t  cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  bqe_quad_t in_quad,
  output logic      geom_valid,
  input  logic      geom_ready,
  output bqe_geom_t geom
);

  localparam logic signed [PROD_W-1:0] TIME_HALF = PROD_W'(1 << (TIME_FRAC - 1));
  localparam logic signed [PROD_W-1:0] DIR_HALF  = PROD_W'(1 << (DIR_FRAC - 1));

  logic      q_valid;
  bqe_quad_t q;

  logic signed [PROD_W-1:0]  vel_prod   [AXES];
  logic signed [PROD_W-1:0]  right_prod [AXES];
  logic signed [PROD_W-1:0]  up_prod    [AXES];
  logic signed [DELTA_W-1:0] delta      [AXES];
  logic signed [SUM_W-1:0]   moved_sum  [AXES];
  logic signed [DIR_W-1:0]   up_eff     [AXES];

  assign in_ready   = !q_valid || geom_ready;
  assign geom_valid = q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q <= in_quad;
    end
  end

  // One multiplier per axis and product, then round half up and saturate the moved centre
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      up_eff[a] = cfg.cylindrical ? ((a == AXIS_Y) ? WORLD_UP_ONE : '0) : $signed(cfg.up[a]);

      vel_prod[a]   = $signed(q.vel[a]) * $signed({1'b0, cfg.time_step}) + TIME_HALF;
      right_prod[a] = $signed(cfg.right[a]) * $signed({1'b0, q.size_x}) + DIR_HALF;
      up_prod[a]    = up_eff[a] * $signed({1'b0, q.size_y}) + DIR_HALF;

      delta[a]     = vel_prod[a][PROD_W-1:TIME_FRAC];
      moved_sum[a] = SUM_W'($signed(q.center[a])) + SUM_W'(delta[a]);

      geom.moved[a] = sat16(moved_sum[a]);
      geom.sr[a]    = right_prod[a][PROD_W-1:DIR_FRAC];
      geom.su[a]    = up_prod[a][PROD_W-1:DIR_FRAC];
    end
  end

endmodule

>>> rtl/core/bqe_corner_gen.sv
// ----------------------------------------------------------------------------
// Billboard quad expander corner generator
// Holds one quad's geometry and emits its four corners into the output register.
// ----------------------------------------------------------------------------
module bqe_corner_gen import bqe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        geom_valid,
  output logic        geom_ready,
  input  bqe_geom_t   geom,
  output logic        out_valid,
  input  logic        out_ready,
  output bqe_corner_t out_corner
);

  logic                g_valid;
  bqe_geom_t           g;
  logic [CORNER_W-1:0] k;
  logic                out_load;
  logic                emit;
  logic                done;
  logic                r_add;
  logic                u_add;
  bqe_corner_t         corner_next;

  logic signed [SUM_W-1:0] m_ext  [AXES];
  logic signed [SUM_W-1:0] sr_ext [AXES];
  logic signed [SUM_W-1:0] su_ext [AXES];
  logic signed [SUM_W-1:0] sum    [AXES];

  assign out_load   = !out_valid || out_ready;
  assign emit       = g_valid && out_load;
  assign done       = emit && (k == CORNER_LAST);
  assign geom_ready = !g_valid || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid   <= 1'b0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (geom_ready) begin
        g_valid <= geom_valid;
      end
      if (emit) begin
        k <= k + 2'd1;
      end
      if (out_load) begin
        out_valid <= g_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (geom_valid && geom_ready) begin
      g <= geom;
    end
    if (emit) begin
      out_corner <= corner_next;
    end
  end

  // Corner order: -r-u, +r-u, +r+u, -r+u
  assign r_add = k[0] ^ k[1];
  assign u_add = k[1];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      m_ext[a]  = SUM_W'($signed(g.moved[a]));
      sr_ext[a] = SUM_W'($signed(g.sr[a]));
      su_ext[a] = SUM_W'($signed(g.su[a]));
      sum[a]    = m_ext[a] + (r_add ? sr_ext[a] : -sr_ext[a])
                           + (u_add ? su_ext[a] : -su_ext[a]);
      corner_next.pos[a] = sat16(sum[a]);
    end
    corner_next.moved  = g.moved;
    corner_next.corner = k;
    corner_next.last   = (k == CORNER_LAST);
  end

endmodule

>>> rtl/core/billboard_quad_expand.sv
// ----------------------------------------------------------------------------
// Billboard quad expander
// Moves a quad centre by its velocity and expands it into four camera-facing
// corners.
// ----------------------------------------------------------------------------
// Each request on the input stream is one quad; it produces four results on the
// output stream, one per cycle while m_axis_tready is high, in the order -r-u,
// +r-u, +r+u, -r+u, with tuser carrying the corner index and tlast marking the
// fourth corner. The first corner of a quad passes through the input register,
// the geometry holding register and the output register. A new quad is taken
// while the previous one is still emitting, so a continuous stream keeps the
// output busy every cycle. All arithmetic is fixed point: positions, sizes and
// velocities are 16-bit Q8.8, directions Q2.14 and the time step unsigned Q0.16;
// products round half towards plus infinity and every position saturates to 16
// bits. Write the registers only while idle.
// ----------------------------------------------------------------------------
`include "billboard_quad_expand_macros.svh"

module billboard_quad_expand import bqe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,

  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,

  // Quad input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // center_x, center_y, center_z, size_x, size_y, vel_x, vel_y, vel_z
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,

  // Corner output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pos_x, pos_y, pos_z, moved_x, moved_y, moved_z
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // corner
  output logic [CORNER_W-1:0]   m_axis_tuser,
  output logic                  m_axis_tlast
);

  bqe_cfg_t    cfg;
  bqe_quad_t   in_quad;
  bqe_geom_t   geom;
  logic        geom_valid;
  logic        geom_ready;
  bqe_corner_t out_corner;

  // The quad record is laid out so that center x lands in the lowest bits
  assign in_quad = bqe_quad_t'(s_axis_tdata);

  bqe_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register, motion and vector scaling
  bqe_quad_math u_quad_math (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_quad    (in_quad),
    .geom_valid (geom_valid),
    .geom_ready (geom_ready),
    .geom       (geom)
  );

  // Hold the scaled geometry and step through the corners
  bqe_corner_gen u_corner_gen (
    .clk        (clk),
    .rst        (rst),
    .geom_valid (geom_valid),
    .geom_ready (geom_ready),
    .geom       (geom),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_corner (out_corner)
  );

  assign m_axis_tdata = {out_corner.moved, out_corner.pos};
  assign m_axis_tuser = out_corner.corner;
  assign m_axis_tlast = out_corner.last;

  // A taken corner other than the last is followed at once by the next one
  `BQE_ASSERT(a_corner_step, clk, rst, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 2'd1), "corner sequence broken")

  // tlast marks exactly the fourth corner
  `BQE_ASSERT(a_last_corner, clk, rst, m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == CORNER_LAST)), "tlast out of step with corner index")

  // The moved centre is the same on all four corners of a quad
  `BQE_ASSERT(a_moved_held, clk, rst, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tdata[M_TDATA_W-1:MOVED_LSB] == $past(m_axis_tdata[M_TDATA_W-1:MOVED_LSB]), "moved centre changed within a quad")

  // Nothing leaves the block during reset
  `BQE_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !m_axis_tvalid, "output valid straight after reset")

endmodule

>>> sim/billboard_quad_expand_tb.sv
// ----------------------------------------------------------------------------
// Billboard quad expander testbench
// Drives quads into the block under a range of camera, cylindrical and time
// step settings. Each corner that comes out is checked against corners worked
// out locally from the quad and the register copy, with random idling on both
// stream sides and a long output hold-off.
// ----------------------------------------------------------------------------
module billboard_quad_expand_tb;
  import bqe_pkg::*;

  // Register indexes in address order
  typedef enum int {
    REG_RIGHT_X, REG_RIGHT_Y, REG_RIGHT_Z,
    REG_UP_X, REG_UP_Y, REG_UP_Z,
    REG_CYLINDRICAL, REG_TIME_STEP
  } reg_idx_t;

  // One corner as it should leave the block; axis 0 in the lowest bits
  typedef struct packed {
    logic [AXES-1:0][COORD_W-1:0] pos;
    logic [AXES-1:0][COORD_W-1:0] moved;
    logic [CORNER_W-1:0]          corner;
    logic                         last;
  } corner_res_t;

  localparam int TAIL_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [REG_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // center_x, center_y, center_z, size_x, size_y, vel_x, vel_y, vel_z
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // pos_x, pos_y, pos_z, moved_x, moved_y, moved_z
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  // corner
  logic [CORNER_W-1:0]   m_axis_tuser;
  logic                  m_axis_tlast;

  // Local copy of the registers, as after reset
  logic signed [DIR_W-1:0] cfg_right [AXES] = '{RESET_ONE, 16'sd0, 16'sd0};
  logic signed [DIR_W-1:0] cfg_up [AXES]    = '{16'sd0, RESET_ONE, 16'sd0};
  logic                    cfg_cyl = 1'b0;
  logic [TIME_W-1:0]       cfg_dt = '0;

  corner_res_t corner_q [$];
  int          mismatch_cnt = 0;
  int          corners_seen = 0;
  int          quads_sent = 0;
  int          settings_cnt = 0;
  bit          src_idle_en = 1'b0;
  logic        sink_idle_en = 1'b0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          sink_gap = 0;

  billboard_quad_expand i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Generous ceiling on the whole run
  initial begin
    #2000000;
    $display("Timed out with %0d corners still awaited", corner_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Corner arithmetic
  // --------------------------------------------------------------------------

  // Divide by 2^s, rounding half towards plus infinity
  function automatic longint round_div_pow2(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_word(input longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[COORD_W-1:0];
  endfunction

  // Work out corner k of a quad under the current register copy
  function automatic corner_res_t corner_of(input bqe_quad_t q, input int k);
    corner_res_t r;
    longint      moved;
    longint      sr;
    longint      su;
    longint      up_dir;
    longint      rs;
    longint      us;
    rs = (k == 1 || k == 2) ? 1 : -1;
    us = (k >= 2) ? 1 : -1;
    r.corner = k[CORNER_W-1:0];
    r.last = (k == 3);
    for (int a = 0; a < AXES; a++) begin
      moved = longint'($signed(q.center[a]))
            + round_div_pow2(longint'($signed(q.vel[a])) * longint'(cfg_dt), TIME_FRAC);
      moved = longint'($signed(clamp_word(moved)));
      if (cfg_cyl) begin
        up_dir = (a == AXIS_Y) ? longint'(WORLD_UP_ONE) : 0;
      end else begin
        up_dir = longint'(cfg_up[a]);
      end
      sr = round_div_pow2(longint'(cfg_right[a]) * longint'(q.size_x), DIR_FRAC);
      su = round_div_pow2(up_dir * longint'(q.size_y), DIR_FRAC);
      r.pos[a] = clamp_word(moved + rs * sr + us * su);
      r.moved[a] = moved[COORD_W-1:0];
    end
    return r;
  endfunction

  function automatic bqe_quad_t make_quad(
    input int cx, input int cy, input int cz, input int sx, input int sy,
    input int vx, input int vy, input int vz);
    bqe_quad_t q;
    q.center[0] = cx[15:0];
    q.center[1] = cy[15:0];
    q.center[2] = cz[15:0];
    q.size_x = sx[15:0];
    q.size_y = sy[15:0];
    q.vel[0] = vx[15:0];
    q.vel[1] = vy[15:0];
    q.vel[2] = vz[15:0];
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Shared tasks
  // --------------------------------------------------------------------------

  task automatic flag_error(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("ERROR: %s", what);
  endtask

  // Write one register, read it back and update the local copy
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    logic [APB_DATA_W-1:0] rd;
    logic [15:0]           want;
    logic [15:0]           got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ADDR_W'(int'(idx) * 4);
    pwdata  <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_RIGHT_X:     cfg_right[0] = val;
      REG_RIGHT_Y:     cfg_right[1] = val;
      REG_RIGHT_Z:     cfg_right[2] = val;
      REG_UP_X:        cfg_up[0] = val;
      REG_UP_Y:        cfg_up[1] = val;
      REG_UP_Z:        cfg_up[2] = val;
      REG_CYLINDRICAL: cfg_cyl = val[0];
      REG_TIME_STEP:   cfg_dt = val;
      default: ;
    endcase
    // the mode flag is one bit wide, so compare only that much of it
    want = (idx == REG_CYLINDRICAL) ? {15'd0, val[0]} : val;
    got  = (idx == REG_CYLINDRICAL) ? {15'd0, rd[0]} : rd[15:0];
    if (got !== want) begin
      flag_error($sformatf("register %s read back %h, wrote %h", idx.name(), got, want));
    end
  endtask

  task automatic write_all(input logic [15:0] rx, input logic [15:0] ry,
                           input logic [15:0] rz, input logic [15:0] ux,
                           input logic [15:0] uy, input logic [15:0] uz,
                           input logic cyl, input logic [15:0] dt);
    write_reg(REG_RIGHT_X, rx);
    write_reg(REG_RIGHT_Y, ry);
    write_reg(REG_RIGHT_Z, rz);
    write_reg(REG_UP_X, ux);
    write_reg(REG_UP_Y, uy);
    write_reg(REG_UP_Z, uz);
    write_reg(REG_CYLINDRICAL, {15'd0, cyl});
    write_reg(REG_TIME_STEP, dt);
    settings_cnt++;
  endtask

  // Offer one quad, optionally after an idle burst, and hold until taken
  task automatic send_quad(input bqe_quad_t q);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= q;
    do @(posedge clk); while (!s_axis_tready);
    for (int k = 0; k < 4; k++) corner_q.push_back(corner_of(q, k));
    quads_sent++;
  endtask

  // Drop the request line and let every awaited corner arrive
  task automatic drain_corners();
    s_axis_tvalid <= 1'b0;
    while (corner_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_word(input bit is_signed);
    case ($urandom_range(0, 5))
      0: return is_signed ? 16'h8000 : 16'h0000;
      1: return is_signed ? 16'h7FFF : 16'hFFFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bqe_quad_t random_quad();
    bqe_quad_t q;
    int        mode;
    mode = $urandom_range(0, 3);
    for (int a = 0; a < AXES; a++) begin
      case (mode)
        0: begin
          q.center[a] = 16'($urandom);
          q.vel[a] = 16'($urandom);
        end
        1: begin
          q.center[a] = 16'($urandom_range(0, 4000)) - 16'd2000;
          q.vel[a] = 16'($urandom_range(0, 1024)) - 16'd512;
        end
        2: begin
          q.center[a] = pick_word(1'b1);
          q.vel[a] = pick_word(1'b1);
        end
        default: begin
          // static quad
          q.center[a] = 16'($urandom_range(0, 16000)) - 16'd8000;
          q.vel[a] = '0;
        end
      endcase
    end
    case (mode)
      0: begin
        q.size_x = 16'($urandom);
        q.size_y = 16'($urandom);
      end
      2: begin
        q.size_x = pick_word(1'b0);
        q.size_y = pick_word(1'b0);
      end
      default: begin
        q.size_x = 16'($urandom_range(0, 1024));
        q.size_y = 16'($urandom_range(0, 1024));
      end
    endcase
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Output side: stall generator and corner checker
  // --------------------------------------------------------------------------

  // Ready is held low for the long hold-off, then in random idle bursts
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
      sink_gap <= $urandom_range(0, 15);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    corner_res_t got;
    corner_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.pos    = m_axis_tdata[MOVED_LSB-1:0];
      got.moved  = m_axis_tdata[M_TDATA_W-1:MOVED_LSB];
      got.corner = m_axis_tuser;
      got.last   = m_axis_tlast;
      corners_seen++;
      if (corner_q.size() == 0) begin
        flag_error($sformatf("corner with nothing awaited: pos %h moved %h idx %0d",
                             got.pos, got.moved, got.corner));
      end else begin
        want = corner_q.pop_front();
        if (got !== want) begin
          flag_error($sformatf({"corner %0d: pos %h/%h moved %h/%h idx %0d/%0d ",
                                "last %b/%b (expected/actual)"},
                               corners_seen, want.pos, got.pos, want.moved, got.moved,
                               want.corner, got.corner, want.last, got.last));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: unit right along x, unit up along y, no motion
  task automatic test_reset_values();
    send_quad(make_quad(0, 0, 0, 0, 0, 0, 0, 0));
    send_quad(make_quad(32767, -32768, 100, 65535, 65535, 32767, -32768, 5));
    send_quad(make_quad(-32768, 32767, -1, 256, 512, -1, 1, 0));
    drain_corners();
  endtask

  // Motion rounding halves in both signs and saturation of the moved centre
  task automatic test_motion();
    write_all(16'd16384, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 1'b0, 16'd32768);
    send_quad(make_quad(0, 0, 0, 16, 16, 1, -1, 3));
    send_quad(make_quad(32767, -32768, 0, 0, 0, 32767, -32768, -3));
    send_quad(make_quad(32000, -32000, 10, 100, 100, 32767, -32768, 0));
    drain_corners();
    write_reg(REG_TIME_STEP, 16'hFFFF);
    send_quad(make_quad(32767, -32768, -32768, 0, 0, 32767, -32768, 32767));
    send_quad(make_quad(-5, 5, 0, 300, 300, -32768, 32767, 1));
    drain_corners();
  endtask

  // World up replaces the camera up vector
  task automatic test_cylindrical();
    write_all(16'd11585, 16'd0, 16'hD2BF, 16'd1234, 16'hB000, 16'd999, 1'b1, 16'd0);
    send_quad(make_quad(100, 200, 300, 1024, 2048, 0, 0, 0));
    send_quad(make_quad(-32768, 32767, 0, 65535, 65535, 0, 0, 0));
    drain_corners();
    write_reg(REG_CYLINDRICAL, 16'd0);
    send_quad(make_quad(100, 200, 300, 1024, 2048, 0, 0, 0));
    drain_corners();
  endtask

  // Extreme directions and sizes, plus rounding halves of the scaled vectors
  task automatic test_direction_extremes();
    write_all(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0, 16'd0);
    send_quad(make_quad(0, 0, 0, 65535, 65535, 0, 0, 0));
    send_quad(make_quad(32767, -32768, 32767, 65535, 0, 0, 0, 0));
    send_quad(make_quad(-32768, 32767, -32768, 0, 65535, 0, 0, 0));
    drain_corners();
    write_all(16'd1, 16'hFFFF, 16'd3, 16'hFFFF, 16'd1, 16'hFFFD, 1'b0, 16'd1);
    send_quad(make_quad(0, 0, 0, 8192, 8192, 32767, -32768, 1));
    send_quad(make_quad(7, -7, 0, 24576, 40960, 0, 0, 0));
    drain_corners();
  endtask

  // Hold the output off for a long stretch while quads keep coming
  task automatic test_backpressure();
    write_all(16'd16384, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 1'b0, 16'd655);
    src_idle_en = 1'b0;
    sink_idle_en <= 1'b0;
    hold_req <= hold_req + 1;
    repeat (30) send_quad(random_quad());
    drain_corners();
  endtask

  // Random settings per phase, random quads, idling off in the last phase
  task automatic test_random();
    for (int ph = 0; ph < 7; ph++) begin
      write_all(pick_word(1'b1), pick_word(1'b1), pick_word(1'b1),
                pick_word(1'b1), pick_word(1'b1), pick_word(1'b1),
                1'($urandom), pick_word(1'b0));
      src_idle_en = (ph < 6);
      sink_idle_en <= (ph < 6);
      for (int n = 0; n < 33; n++) begin
        send_quad(random_quad());
        // now and then let the output run dry mid-phase
        if ($urandom_range(0, 39) == 0) drain_corners();
      end
      drain_corners();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_motion();
    test_cylindrical();
    test_direction_extremes();
    test_backpressure();
    test_random();
    $display("Sent %0d quads under %0d register settings, checked %0d corners",
             quads_sent, settings_cnt, corners_seen);
    $display("including saturation, rounding halves, world up and a long output stall");
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
